/* rtl/core/feeder_unjam_sequencer_macros.svh */
// Assertion macros shared by the feeder unjam sequencer RTL.
`ifndef FEEDER_UNJAM_SEQUENCER_MACROS_SVH
`define FEEDER_UNJAM_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define FUS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fus assertion failed");
// Next-cycle implication, checked outside reset.
`define FUS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fus assertion failed");
`else
`define FUS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FUS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/fus_pkg.sv */
// Types, constants and helper functions of the feeder unjam sequencer.
package fus_pkg;

	localparam int AngleW = 32;
	localparam int TimeW = 32;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;

	// Register indexes of the configuration port.
	localparam logic [CfgIdxW-1:0] REG_MAX_BACKOFF = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_MIN_BACKOFF = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_MAX_WAIT = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_TOLERANCE = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_SALV_TIMEOUT = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_SALV_WAIT = 3'd5;

	// Operation codes of a request.
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// A full turn, 2 pi in Q16.16, sign-extended to the difference width.
	localparam logic [AngleW:0] FULL_TURN = 33'd411775;

	// Clamps a 33-bit two's complement difference into the signed 32-bit range.
	function automatic logic [AngleW-1:0] sat32(input logic [AngleW:0] v);
		logic [AngleW-1:0] r;
		if (v[AngleW] != v[AngleW-1]) begin
			r = v[AngleW] ? {1'b1, {(AngleW-1){1'b0}}} : {1'b0, {(AngleW-1){1'b1}}};
		end else begin
			r = v[AngleW-1:0];
		end
		return r;
	endfunction

	// True when |meas - cmd| is strictly below the tolerance.
	function automatic logic within_tol(input logic [AngleW-1:0] meas,
			input logic [AngleW-1:0] cmd, input logic [AngleW-2:0] tol);
		logic [AngleW:0] d;
		logic [AngleW:0] mag;
		d = {meas[AngleW-1], meas} - {cmd[AngleW-1], cmd};
		mag = d[AngleW] ? (~d + 33'd1) : d;
		return mag < {2'b00, tol};
	endfunction

endpackage

/* rtl/core/fus_if.sv */
// Valid/ready channels carrying the requests and results of the unjam sequencer.
interface fus_req_if;
	logic valid;
	logic ready;
	logic operation;
	logic [31:0] now_ms;
	logic signed [31:0] measured_angle;
	logic signed [31:0] current_setpoint;
	logic [14:0] random_value;

	modport source (output valid, operation, now_ms, measured_angle, current_setpoint,
		random_value, input ready);
	modport sink (input valid, operation, now_ms, measured_angle, current_setpoint,
		random_value, output ready);
endinterface

interface fus_res_if;
	logic valid;
	logic ready;
	logic drive_valid;
	logic signed [31:0] commanded_angle;
	logic finished;

	modport source (output valid, drive_valid, commanded_angle, finished, input ready);
	modport sink (input valid, drive_valid, commanded_angle, finished, output ready);
endinterface

/* rtl/core/feeder_unjam_sequencer.sv */
// Unjam sequencer for a rotary feeder: back-off, forward and full-turn phases.
// A request is taken only while idle; its result is registered after the divide and execute
// states, and the execute state holds while the output register is full. The random back-off
// angle comes from a restoring subtractor that retires one remainder bit per cycle.
// A finished result waits in the output register while the next request is taken.
// Reset (arst_n low) restores the register defaults and clears every phase and timer.
`include "feeder_unjam_sequencer_macros.svh"

module feeder_unjam_sequencer
	import fus_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	fus_req_if.sink             request,
	fus_res_if.source           result,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_EXEC
	} seq_state_t;

	typedef enum logic [1:0] {
		PH_BACK,
		PH_FORWARD,
		PH_SALV,
		PH_DONE
	} phase_t;

	localparam int DivW = 31;
	localparam logic [4:0] LastStep = 5'(DivW - 1);

	seq_state_t state_q;
	phase_t phase_q;

	// Configuration.
	logic [30:0] max_backoff_q, min_backoff_q, tolerance_q;
	logic [TimeW-1:0] max_wait_q, salv_timeout_q, salv_wait_q;

	// Sequencer state.
	logic [AngleW-1:0] target_q, saved_q;
	logic ph_run_q, salv_armed_q;
	logic [TimeW-1:0] ph_start_q, ph_len_q, salv_start_q, salv_len_q;

	// Captured request and divider.
	logic op_q;
	logic [TimeW-1:0] now_q;
	logic [AngleW-1:0] meas_q, setp_q;
	logic [DivW-1:0] divd_q, rem_q;
	logic [4:0] cnt_q;

	// Output register.
	logic out_valid_q, out_drive_q, out_finished_q;
	logic [AngleW-1:0] out_cmd_q;

	logic [30:0] hi_angle, span;
	logic [DivW:0] trial;
	logic [DivW-1:0] rem_next;
	logic [AngleW-1:0] angle, base, rnd_target, full_target, tgt_cur;
	logic salv_exp, tim_run, tmo, reach_tgt, reach_sav;
	logic [TimeW-1:0] tim_start, tim_len;
	phase_t ph_cur, nx_phase;
	logic [AngleW-1:0] nx_target, nx_saved, nx_cmd;
	logic nx_ph_run, nx_salv_armed, nx_drive;
	logic [TimeW-1:0] nx_ph_start, nx_ph_len, nx_salv_start, nx_salv_len;
	logic req_fire, out_free, exec_done;

	assign request.ready = (state_q == ST_IDLE);
	assign req_fire = request.valid && request.ready;
	assign out_free = !out_valid_q || result.ready;
	assign exec_done = (state_q == ST_EXEC) && out_free;

	assign result.valid = out_valid_q;
	assign result.drive_valid = out_drive_q;
	assign result.commanded_angle = out_cmd_q;
	assign result.finished = out_finished_q;

	// A maximum below the minimum counts as the minimum.
	assign hi_angle = (max_backoff_q < min_backoff_q) ? min_backoff_q : max_backoff_q;
	assign span = hi_angle - min_backoff_q;

	// One restoring step: shift in the next dividend bit, subtract the span if it fits.
	assign trial = {rem_q, divd_q[DivW-1]};
	assign rem_next = (trial >= {1'b0, span}) ? DivW'(trial - {1'b0, span}) : trial[DivW-1:0];

	always_comb begin
		angle = {1'b0, ((span == '0) ? 31'd0 : rem_q)} + {1'b0, min_backoff_q};
		base = (op_q == OP_START) ? meas_q : saved_q;
		rnd_target = sat32({base[AngleW-1], base} - {1'b0, angle});
		full_target = sat32({saved_q[AngleW-1], saved_q} - FULL_TURN);

		salv_exp = salv_armed_q && ((now_q - salv_start_q) >= salv_len_q);
		tim_run = ph_run_q || salv_exp;
		tim_start = salv_exp ? now_q : ph_start_q;
		tim_len = salv_exp ? salv_wait_q : ph_len_q;
		tmo = tim_run && ((now_q - tim_start) >= tim_len);
		ph_cur = salv_exp ? PH_SALV : phase_q;
		tgt_cur = salv_exp ? full_target : target_q;
		reach_tgt = within_tol(meas_q, tgt_cur, tolerance_q);
		reach_sav = within_tol(meas_q, saved_q, tolerance_q);

		nx_phase = ph_cur;
		nx_target = tgt_cur;
		nx_saved = saved_q;
		nx_ph_run = tim_run;
		nx_ph_start = tim_start;
		nx_ph_len = tim_len;
		nx_salv_armed = salv_armed_q && !salv_exp;
		nx_salv_start = salv_start_q;
		nx_salv_len = salv_len_q;
		nx_drive = 1'b0;
		nx_cmd = '0;

		if (op_q == OP_START) begin
			nx_phase = PH_BACK;
			nx_target = rnd_target;
			nx_saved = setp_q;
			nx_ph_run = 1'b1;
			nx_ph_start = now_q;
			nx_ph_len = max_wait_q;
			nx_salv_armed = 1'b1;
			nx_salv_start = now_q;
			nx_salv_len = salv_timeout_q;
		end else begin
			case (ph_cur)
				PH_SALV: begin
					nx_drive = 1'b1;
					nx_cmd = tgt_cur;
					if (tmo || reach_tgt) begin
						nx_phase = PH_DONE;
					end
				end
				PH_BACK: begin
					nx_drive = 1'b1;
					nx_cmd = tgt_cur;
					if (tmo || reach_tgt) begin
						nx_ph_run = 1'b1;
						nx_ph_start = now_q;
						nx_ph_len = max_wait_q;
						nx_phase = PH_FORWARD;
					end
				end
				PH_FORWARD: begin
					nx_drive = 1'b1;
					nx_cmd = saved_q;
					if (tmo) begin
						// Forward move stalled: retry with a fresh back-off from the setpoint.
						nx_ph_run = 1'b1;
						nx_ph_start = now_q;
						nx_ph_len = max_wait_q;
						nx_target = rnd_target;
						nx_phase = PH_BACK;
					end else if (reach_sav) begin
						nx_phase = PH_DONE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_BACK;
			max_backoff_q <= 31'd102944;
			min_backoff_q <= 31'd25736;
			max_wait_q <= 32'd130;
			tolerance_q <= 31'd6554;
			salv_timeout_q <= 32'd2000;
			salv_wait_q <= 32'd1000;
			target_q <= '0;
			saved_q <= '0;
			ph_run_q <= 1'b0;
			ph_start_q <= '0;
			ph_len_q <= '0;
			salv_armed_q <= 1'b0;
			salv_start_q <= '0;
			salv_len_q <= '0;
			op_q <= OP_START;
			now_q <= '0;
			meas_q <= '0;
			setp_q <= '0;
			divd_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			out_drive_q <= 1'b0;
			out_finished_q <= 1'b0;
			out_cmd_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_BACKOFF: max_backoff_q <= cfg_wdata[30:0];
					REG_MIN_BACKOFF: min_backoff_q <= cfg_wdata[30:0];
					REG_MAX_WAIT: max_wait_q <= cfg_wdata;
					REG_TOLERANCE: tolerance_q <= cfg_wdata[30:0];
					REG_SALV_TIMEOUT: salv_timeout_q <= cfg_wdata;
					REG_SALV_WAIT: salv_wait_q <= cfg_wdata;
					default: begin
					end
				endcase
			end

			if (exec_done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						op_q <= request.operation;
						now_q <= request.now_ms;
						meas_q <= request.measured_angle;
						setp_q <= request.current_setpoint;
						divd_q <= {request.random_value, 16'd0};
						rem_q <= '0;
						cnt_q <= '0;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					rem_q <= rem_next;
					divd_q <= {divd_q[DivW-2:0], 1'b0};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == LastStep) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						phase_q <= nx_phase;
						target_q <= nx_target;
						saved_q <= nx_saved;
						ph_run_q <= nx_ph_run;
						ph_start_q <= nx_ph_start;
						ph_len_q <= nx_ph_len;
						salv_armed_q <= nx_salv_armed;
						salv_start_q <= nx_salv_start;
						salv_len_q <= nx_salv_len;
						out_drive_q <= nx_drive;
						out_cmd_q <= nx_cmd;
						out_finished_q <= (nx_phase == PH_DONE);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`FUS_ASSERT_NEXT(a_accept_starts_divide, clk, arst_n, req_fire, state_q == ST_MOD)
	`FUS_ASSERT_IMP(a_result_from_exec, clk, arst_n, $rose(out_valid_q), $past(state_q == ST_EXEC))
	`FUS_ASSERT_NEXT(a_finished_phase, clk, arst_n, exec_done, out_finished_q == (phase_q == PH_DONE))
	`FUS_ASSERT_IMP(a_remainder_below_span, clk, arst_n, state_q == ST_EXEC, (span == '0) || (rem_q < span))

endmodule
